// ===== design/edc_pkg.sv =====
package edc_pkg;

  typedef struct packed {
    logic signed [15:0] a_pos_x;
    logic signed [15:0] a_pos_y;
    logic signed [15:0] a_vel_x;
    logic signed [15:0] a_vel_y;
    logic [11:0]        a_mass;
    logic [11:0]        a_radius;
    logic signed [15:0] b_pos_x;
    logic signed [15:0] b_pos_y;
    logic signed [15:0] b_vel_x;
    logic signed [15:0] b_vel_y;
    logic [11:0]        b_mass;
    logic [11:0]        b_radius;
  } in_t;

  typedef struct packed {
    logic signed [15:0] a_new_vel_x;
    logic signed [15:0] a_new_vel_y;
    logic signed [15:0] b_new_vel_x;
    logic signed [15:0] b_new_vel_y;
    logic               collided;
    logic               clipped;
  } out_t;

  // ratio divider: (|dot| << 16 + n/2) / n
  localparam int unsigned RatioNumW = 48;
  localparam int unsigned RatioDenW = 26;
  localparam int unsigned RatioQuoW = 35;

  // impulse divider: ((|k*p| + m*2^15) >> 16) / m, quotient clamped at 2^18
  localparam int unsigned ImpNumW = 33;
  localparam int unsigned ImpDenW = 13;
  localparam int unsigned ImpQuoW = 18;
  localparam int unsigned Lanes   = 4;

  typedef struct packed {
    logic               collide;
    logic               neg;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [3:0][15:0]   vel;
    logic [11:0]        am;
    logic [11:0]        bm;
  } ratio_side_t;

  typedef struct packed {
    logic             collide;
    logic [3:0]       neg;
    logic [3:0]       ovf;
    logic [3:0][15:0] vel;
  } imp_side_t;

endpackage

// ===== design/edc_div.sv =====
module edc_div #(
  parameter int unsigned NLanes = 1,
  parameter int unsigned NumW   = 48,
  parameter int unsigned DenW   = 26,
  parameter int unsigned QuoW   = 35,
  parameter int unsigned SideW  = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [NLanes-1:0][NumW-1:0]   num_i,
  input  logic [NLanes-1:0][DenW-1:0]   den_i,
  input  logic [SideW-1:0]              side_i,
  output logic                          valid_o,
  output logic [NLanes-1:0][QuoW-1:0]   quo_o,
  output logic [SideW-1:0]              side_o
);

  // caller keeps num < den << QuoW; one quotient bit per stage, MSB first
  localparam int unsigned RemW = (NumW > DenW + QuoW) ? NumW : DenW + QuoW;

  logic [NLanes-1:0][RemW-1:0] rem_q [QuoW];
  logic [NLanes-1:0][DenW-1:0] den_q [QuoW];
  logic [NLanes-1:0][QuoW-1:0] quo_q [QuoW];
  logic [SideW-1:0]            side_q [QuoW];
  logic [QuoW-1:0]             vld_q;

  for (genvar k = 0; k < QuoW; k++) begin : g_stage
    logic [NLanes-1:0][RemW-1:0] rem_in, rem_d;
    logic [NLanes-1:0][DenW-1:0] den_in;
    logic [NLanes-1:0][QuoW-1:0] quo_in, quo_d;
    logic [SideW-1:0]            side_in;
    logic                        vld_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < NLanes; l++) begin
          rem_in[l] = RemW'(num_i[l]);
        end
      end
      assign den_in  = den_i;
      assign quo_in  = '0;
      assign side_in = side_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign quo_in  = quo_q[k-1];
      assign side_in = side_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    always_comb begin
      logic [RemW-1:0] trial;
      for (int l = 0; l < NLanes; l++) begin
        trial    = RemW'(den_in[l]) << (QuoW - 1 - k);
        rem_d[l] = rem_in[l];
        quo_d[l] = quo_in[l];
        if (rem_in[l] >= trial) begin
          rem_d[l]             = rem_in[l] - trial;
          quo_d[l][QuoW-1-k]   = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        den_q[k]  <= den_in;
        quo_q[k]  <= quo_d;
        side_q[k] <= side_in;
      end
    end
  end

  assign valid_o = vld_q[QuoW-1];
  assign quo_o   = quo_q[QuoW-1];
  assign side_o  = side_q[QuoW-1];

endmodule

// ===== design/elastic_disc_collision.sv =====
// Stages: 3 front stages, 35-stage ratio divider, 4 multiply/scale stages,
// 18-stage impulse divider, output register.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds in place while the output register is full and not taken.
// Reset: asynchronous, active low; clears all stage valid bits, data is not reset.
module elastic_disc_collision import edc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  in_t  in_data_i,
  output logic in_ready_o,
  output logic out_valid_o,
  output out_t out_data_o,
  input  logic out_ready_i
);

  logic en;
  logic out_valid_q;
  out_t out_q, out_d;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // stage 1: differences, radius sum and mass sum
  logic               v1_q;
  logic signed [16:0] dx1_q, dy1_q, dvx1_q, dvy1_q;
  logic [12:0]        rs1_q, ms1_q;
  logic [3:0][15:0]   vel1_q;
  logic [11:0]        am1_q, bm1_q;

  // stage 2: squares and products
  logic               v2_q;
  logic [33:0]        n2_q;
  logic [25:0]        rs2_q;
  logic signed [33:0] tx2_q, ty2_q;
  logic signed [16:0] dx2_q, dy2_q;
  logic [12:0]        ms2_q;
  logic [3:0][15:0]   vel2_q;
  logic [11:0]        am2_q, bm2_q;

  // stage 3: overlap test and dot product
  logic               v3_q, col3_q;
  logic signed [34:0] dot3_q;
  logic [25:0]        n3_q;
  logic signed [16:0] dx3_q, dy3_q;
  logic [3:0][15:0]   vel3_q;
  logic [11:0]        am3_q, bm3_q;

  logic signed [33:0] sqx, sqy, tx, ty;
  logic [34:0]        dmag;
  ratio_side_t        rs_in, rs_out;
  logic [0:0][RatioNumW-1:0] r_num;
  logic [0:0][RatioDenW-1:0] r_den;
  logic [0:0][RatioQuoW-1:0] r_quo;
  logic               vd1;

  assign sqx  = dx1_q * dx1_q;
  assign sqy  = dy1_q * dy1_q;
  assign tx   = dvx1_q * dx1_q;
  assign ty   = dvy1_q * dy1_q;
  assign dmag = dot3_q[34] ? 35'(-dot3_q) : 35'(dot3_q);

  always_comb begin
    r_num[0] = '0;
    r_den[0] = RatioDenW'(1);
    if (col3_q) begin
      r_num[0] = (RatioNumW'(dmag[31:0]) << 16) + RatioNumW'(n3_q[25:1]);
      r_den[0] = n3_q;
    end
    rs_in.collide = col3_q;
    rs_in.neg     = dot3_q[34];
    rs_in.dx      = dx3_q;
    rs_in.dy      = dy3_q;
    rs_in.vel     = vel3_q;
    rs_in.am      = am3_q;
    rs_in.bm      = bm3_q;
  end

  edc_div #(
    .NLanes (1),
    .NumW   (RatioNumW),
    .DenW   (RatioDenW),
    .QuoW   (RatioQuoW),
    .SideW  ($bits(ratio_side_t))
  ) u_ratio_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (r_num),
    .den_i   (r_den),
    .side_i  (rs_in),
    .valid_o (vd1),
    .quo_o   (r_quo),
    .side_o  (rs_out)
  );

  // stage 4: projection s * d
  logic               v4_q, col4_q;
  logic signed [35:0] px4_q, py4_q;
  logic [12:0]        ka4_q, kb4_q, ms4_q;
  logic [3:0][15:0]   vel4_q;

  // stage 5: mass-weighted impulse numerators
  logic               v5_q, col5_q;
  logic [3:0][49:0]   kp5_q;
  logic [12:0]        ms5_q;
  logic [3:0][15:0]   vel5_q;

  // stage 6: sign and magnitude
  logic               v6_q, col6_q;
  logic [3:0][47:0]   mag6_q;
  logic [3:0]         neg6_q;
  logic [12:0]        ms6_q;
  logic [3:0][15:0]   vel6_q;

  // stage 7: rounding bias, scale and clamp check
  logic               v7_q, col7_q;
  logic [3:0][ImpNumW-1:0] n7_q;
  logic [3:0]         ovf7_q, neg7_q;
  logic [12:0]        ms7_q;
  logic [3:0][15:0]   vel7_q;

  logic signed [35:0] s4;
  logic signed [52:0] px_w, py_w;
  logic [3:0][49:0]   kp;
  logic [3:0][47:0]   mag;
  logic [3:0][ImpNumW-1:0] nsc;
  logic [3:0]         ovf;

  assign s4   = rs_out.neg ? -$signed({1'b0, r_quo[0]}) : $signed({1'b0, r_quo[0]});
  assign px_w = s4 * rs_out.dx;
  assign py_w = s4 * rs_out.dy;

  always_comb begin
    logic signed [49:0] prod;
    logic [48:0]        biased;
    for (int l = 0; l < Lanes; l++) begin
      prod = $signed({1'b0, (l < 2) ? ka4_q : kb4_q}) * (l[0] ? py4_q : px4_q);
      kp[l] = prod;
      mag[l] = kp5_q[l][49] ? 48'(-$signed(kp5_q[l])) : kp5_q[l][47:0];
      biased = 49'(mag6_q[l]) + (49'(ms6_q) << 15);
      nsc[l] = biased[48:16];
      ovf[l] = nsc[l] >= (ImpNumW'(ms6_q) << ImpQuoW);
    end
  end

  imp_side_t                   is_in, is_out;
  logic [3:0][ImpNumW-1:0]     i_num;
  logic [3:0][ImpDenW-1:0]     i_den;
  logic [3:0][ImpQuoW-1:0]     i_quo;
  logic                        vd2;

  always_comb begin
    for (int l = 0; l < Lanes; l++) begin
      i_num[l] = ovf7_q[l] ? '0 : n7_q[l];
      i_den[l] = ms7_q;
    end
    is_in.collide = col7_q;
    is_in.neg     = neg7_q;
    is_in.ovf     = ovf7_q;
    is_in.vel     = vel7_q;
  end

  edc_div #(
    .NLanes (Lanes),
    .NumW   (ImpNumW),
    .DenW   (ImpDenW),
    .QuoW   (ImpQuoW),
    .SideW  ($bits(imp_side_t))
  ) u_imp_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (i_num),
    .den_i   (i_den),
    .side_i  (is_in),
    .valid_o (vd2),
    .quo_o   (i_quo),
    .side_o  (is_out)
  );

  // output: apply impulse, saturate
  always_comb begin
    logic [3:0][15:0]   nv;
    logic [ImpQuoW:0]   delta;
    logic signed [20:0] sd, res;
    logic               clip;
    clip = 1'b0;
    for (int l = 0; l < Lanes; l++) begin
      delta = is_out.ovf[l] ? (19'(1) << ImpQuoW) : {1'b0, i_quo[l]};
      sd    = is_out.neg[l] ? -$signed(21'(delta)) : $signed(21'(delta));
      if (l < 2) begin
        res = 21'($signed(is_out.vel[l])) - sd;
      end else begin
        res = 21'($signed(is_out.vel[l])) + sd;
      end
      nv[l] = res[15:0];
      if (res > 21'sd32767) begin
        nv[l] = 16'h7fff;
        clip  = 1'b1;
      end else if (res < -21'sd32768) begin
        nv[l] = 16'h8000;
        clip  = 1'b1;
      end
    end
    if (!is_out.collide) begin
      nv   = is_out.vel;
      clip = 1'b0;
    end
    out_d.a_new_vel_x = nv[0];
    out_d.a_new_vel_y = nv[1];
    out_d.b_new_vel_x = nv[2];
    out_d.b_new_vel_y = nv[3];
    out_d.collided    = is_out.collide;
    out_d.clipped     = clip;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      v7_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= vd1;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      v7_q        <= v6_q;
      out_valid_q <= vd2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx1_q  <= 17'(in_data_i.a_pos_x) - 17'(in_data_i.b_pos_x);
      dy1_q  <= 17'(in_data_i.a_pos_y) - 17'(in_data_i.b_pos_y);
      dvx1_q <= 17'(in_data_i.a_vel_x) - 17'(in_data_i.b_vel_x);
      dvy1_q <= 17'(in_data_i.a_vel_y) - 17'(in_data_i.b_vel_y);
      rs1_q  <= 13'(in_data_i.a_radius) + 13'(in_data_i.b_radius);
      ms1_q  <= 13'(in_data_i.a_mass) + 13'(in_data_i.b_mass);
      vel1_q <= {in_data_i.b_vel_y, in_data_i.b_vel_x, in_data_i.a_vel_y, in_data_i.a_vel_x};
      am1_q  <= in_data_i.a_mass;
      bm1_q  <= in_data_i.b_mass;

      n2_q   <= 34'(sqx) + 34'(sqy);
      rs2_q  <= rs1_q * rs1_q;
      tx2_q  <= tx;
      ty2_q  <= ty;
      dx2_q  <= dx1_q;
      dy2_q  <= dy1_q;
      ms2_q  <= ms1_q;
      vel2_q <= vel1_q;
      am2_q  <= am1_q;
      bm2_q  <= bm1_q;

      // coincident centres or zero mass sum count as no collision
      col3_q <= (n2_q != '0) && (n2_q < 34'(rs2_q)) && (ms2_q != '0);
      dot3_q <= 35'(tx2_q) + 35'(ty2_q);
      n3_q   <= n2_q[25:0];
      dx3_q  <= dx2_q;
      dy3_q  <= dy2_q;
      vel3_q <= vel2_q;
      am3_q  <= am2_q;
      bm3_q  <= bm2_q;

      col4_q <= rs_out.collide;
      px4_q  <= px_w[35:0];
      py4_q  <= py_w[35:0];
      ka4_q  <= {rs_out.bm, 1'b0};
      kb4_q  <= {rs_out.am, 1'b0};
      ms4_q  <= 13'(rs_out.am) + 13'(rs_out.bm);
      vel4_q <= rs_out.vel;

      col5_q <= col4_q;
      kp5_q  <= kp;
      ms5_q  <= ms4_q;
      vel5_q <= vel4_q;

      col6_q <= col5_q;
      mag6_q <= mag;
      for (int l = 0; l < Lanes; l++) begin
        neg6_q[l] <= kp5_q[l][49];
      end
      ms6_q  <= ms5_q;
      vel6_q <= vel5_q;

      col7_q <= col6_q;
      n7_q   <= nsc;
      ovf7_q <= ovf;
      neg7_q <= neg6_q;
      ms7_q  <= ms6_q;
      vel7_q <= vel6_q;

      out_q  <= out_d;
    end
  end

endmodule

// ===== design/edc_chk.sv =====
module edc_chk import edc_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input in_t  in_data_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input out_t out_data_o,
  input logic out_ready_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_clip_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.collided |-> !out_data_o.clipped)
    else $error("clipped without collision");

  a_ready_follows_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready disagrees with output stall");

endmodule

bind elastic_disc_collision edc_chk u_edc_chk (.*);

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import edc_pkg::*;

  localparam int unsigned InW = $bits(in_t);

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  in_t  in_data_i = '0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;
  logic out_ready_i = 1'b0;

  out_t expected_vels[$];
  int   fail_cnt = 0;
  bit   src_idle_en = 1'b1;
  bit   sink_idle_en = 1'b1;
  bit   hold_sink = 1'b0;

  elastic_disc_collision u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_data_i  (in_data_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_data_o (out_data_o),
    .out_ready_i(out_ready_i)
  );

  always #10 clk_i = ~clk_i;

  function automatic longint round_div(longint num, longint den);
    longint mag;
    longint q;
    mag = num < 0 ? -num : num;
    q = (mag + den / 2) / den;
    return num < 0 ? -q : q;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v, ref bit clip);
    if (v > 32767) begin
      clip = 1'b1;
      return 16'sh7fff;
    end
    if (v < -32768) begin
      clip = 1'b1;
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  function automatic out_t predict_bounce(in_t d);
    out_t   r;
    longint dx, dy, n, rs, msum, dot, s, px, py, den, ka, kb;
    bit     clip;
    clip = 1'b0;
    dx = longint'(d.a_pos_x) - longint'(d.b_pos_x);
    dy = longint'(d.a_pos_y) - longint'(d.b_pos_y);
    n = dx * dx + dy * dy;
    rs = longint'(d.a_radius) + longint'(d.b_radius);
    msum = longint'(d.a_mass) + longint'(d.b_mass);
    r.a_new_vel_x = d.a_vel_x;
    r.a_new_vel_y = d.a_vel_y;
    r.b_new_vel_x = d.b_vel_x;
    r.b_new_vel_y = d.b_vel_y;
    r.collided = 1'b0;
    r.clipped = 1'b0;
    if (n == 0 || n >= rs * rs || msum == 0) return r;
    dot = (longint'(d.a_vel_x) - longint'(d.b_vel_x)) * dx
        + (longint'(d.a_vel_y) - longint'(d.b_vel_y)) * dy;
    s = round_div(dot * 65536, n);
    px = s * dx;
    py = s * dy;
    den = msum * 65536;
    ka = 2 * longint'(d.b_mass);
    kb = 2 * longint'(d.a_mass);
    r.a_new_vel_x = clamp16(longint'(d.a_vel_x) - round_div(ka * px, den), clip);
    r.a_new_vel_y = clamp16(longint'(d.a_vel_y) - round_div(ka * py, den), clip);
    r.b_new_vel_x = clamp16(longint'(d.b_vel_x) + round_div(kb * px, den), clip);
    r.b_new_vel_y = clamp16(longint'(d.b_vel_y) + round_div(kb * py, den), clip);
    r.collided = 1'b1;
    r.clipped = clip;
    return r;
  endfunction

  // one request: hold valid until accepted, optional idle burst afterward
  task automatic send_pair(in_t d);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    expected_vels = {expected_vels, predict_bounce(d)};
    if (src_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic finish_sending();
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_vels.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data_o);
        fail_cnt++;
      end else begin
        out_t e;
        e = expected_vels.pop_front();
        if (e.a_new_vel_x !== out_data_o.a_new_vel_x) begin
          $display("%0t: a_new_vel_x exp %0d got %0d", $time, e.a_new_vel_x,
                   out_data_o.a_new_vel_x);
          fail_cnt++;
        end
        if (e.a_new_vel_y !== out_data_o.a_new_vel_y) begin
          $display("%0t: a_new_vel_y exp %0d got %0d", $time, e.a_new_vel_y,
                   out_data_o.a_new_vel_y);
          fail_cnt++;
        end
        if (e.b_new_vel_x !== out_data_o.b_new_vel_x) begin
          $display("%0t: b_new_vel_x exp %0d got %0d", $time, e.b_new_vel_x,
                   out_data_o.b_new_vel_x);
          fail_cnt++;
        end
        if (e.b_new_vel_y !== out_data_o.b_new_vel_y) begin
          $display("%0t: b_new_vel_y exp %0d got %0d", $time, e.b_new_vel_y,
                   out_data_o.b_new_vel_y);
          fail_cnt++;
        end
        if (e.collided !== out_data_o.collided) begin
          $display("%0t: collided exp %0b got %0b", $time, e.collided,
                   out_data_o.collided);
          fail_cnt++;
        end
        if (e.clipped !== out_data_o.clipped) begin
          $display("%0t: clipped exp %0b got %0b", $time, e.clipped,
                   out_data_o.clipped);
          fail_cnt++;
        end
      end
    end
  end

  // receiver: bursts of stall, or a long hold when requested
  initial begin
    int n;
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        out_ready_i <= 1'b0;
        n = 0;
        while (hold_sink) begin
          @(posedge clk_i);
          n++;
          if (n == 150) hold_sink = 1'b0;
        end
        out_ready_i <= 1'b1;
      end else if (sink_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready_i <= 1'b0;
        n = $urandom_range(1, 13);
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  function automatic in_t rand_pair(bit close);
    in_t d;
    d = InW'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    d.a_mass = 12'($urandom_range(1, 4095));
    d.b_mass = 12'($urandom_range(1, 4095));
    if (close) begin
      // nearby centres with radii large enough to overlap most of the time
      d.b_pos_x = d.a_pos_x + 16'($signed($urandom_range(0, 1600)) - 800);
      d.b_pos_y = d.a_pos_y + 16'($signed($urandom_range(0, 1600)) - 800);
      d.a_radius = 12'($urandom_range(0, 700));
      d.b_radius = 12'($urandom_range(0, 700));
      if ($urandom_range(0, 3) == 0) begin
        d.a_vel_x = 16'($signed($urandom_range(0, 1023)) - 512);
        d.a_vel_y = 16'($signed($urandom_range(0, 1023)) - 512);
      end
    end
    return d;
  endfunction

  task automatic test_directed();
    in_t d;
    d = '0;
    d.a_mass = 12'h100; d.b_mass = 12'h100;
    d.a_radius = 12'h100; d.b_radius = 12'h100;
    send_pair(d);                            // coincident centres
    d.a_pos_x = 16'sd64; d.a_vel_x = -16'sd4096; d.b_vel_x = 16'sd4096;
    send_pair(d);                            // head-on, equal masses
    d.a_pos_x = 16'sd8192;
    send_pair(d);                            // no overlap
    d.a_pos_x = 16'sd512;
    send_pair(d);                            // exactly touching: no collision
    d.a_pos_x = 16'sd511;
    send_pair(d);
    d.a_radius = 12'hfff; d.b_radius = 12'hfff;
    d.a_pos_x = 16'sh7fff; d.b_pos_x = 16'sh7f00;
    d.a_pos_y = -16'sh8000; d.b_pos_y = -16'sh7f00;
    d.a_vel_x = -16'sh8000; d.a_vel_y = 16'sh7fff;
    d.b_vel_x = 16'sh7fff; d.b_vel_y = -16'sh8000;
    send_pair(d);                            // saturation
    d.a_mass = 12'd1; d.b_mass = 12'hfff;
    send_pair(d);
    d.a_mass = 12'hfff; d.b_mass = 12'd1;
    send_pair(d);
    d.a_pos_x = 16'sh7fff; d.b_pos_x = -16'sh8000;
    d.a_pos_y = 16'sh7fff; d.b_pos_y = -16'sh8000;
    send_pair(d);                            // widest separation
    d.b_pos_x = 16'sh7ffe; d.b_pos_y = 16'sh7fff;
    d.a_radius = 12'd0; d.b_radius = 12'd1;
    send_pair(d);                            // unit distance, radius sum 1: touching, no collision
    d.b_radius = 12'd0;
    send_pair(d);                            // zero radii
    d = '1;
    send_pair(d);
    repeat (8) send_pair(rand_pair(1'b1));
  endtask

  task automatic test_random();
    repeat (220) send_pair(rand_pair($urandom_range(0, 3) != 0));
  endtask

  task automatic test_backpressure();
    hold_sink = 1'b1;
    repeat (100) send_pair(rand_pair(1'b1));
  endtask

  task automatic test_full_rate();
    src_idle_en = 1'b0;
    sink_idle_en = 1'b0;
    repeat (60) send_pair(rand_pair(1'b1));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_full_rate();
    finish_sending();
    while (expected_vels.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (fail_cnt == 0 && expected_vels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/edc_pkg.sv
design/edc_div.sv
design/elastic_disc_collision.sv
design/edc_chk.sv
test/tb.sv
